/* rtl/obl_pkg.sv */
// Package for the order book level table: codes, entry type and the
// command/status structs between controller and datapath. No dependencies.
package obl_pkg;

	localparam int MAX_LEVELS_DEF = 128;
	localparam logic [6:0] PRICE_TOP = 7'd100;
	localparam logic [30:0] QTY_MAX = 31'h7FFF_FFFF;

	typedef enum logic [1:0] {
		CMD_APPLY = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_REMOVED  = 3'd1,
		ST_INSERTED = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	typedef struct packed {
		logic [6:0]  price;
		logic [30:0] qty;
	} entry_t;

	// read address source
	typedef enum logic [1:0] {RA_I, RA_I1, RA_J1, RA_IDX} ra_t;
	// write address source
	typedef enum logic {WA_I, WA_J} wa_t;
	// write data source
	typedef enum logic [1:0] {WD_RD, WD_SUM, WD_NEW} wd_t;
	// level count operation
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV,
		S_SHL_RD, S_SHL_WR, S_SHR_RD, S_SHR_WR, S_DONE
	} state_t;

	typedef struct packed {
		logic    load_in;
		logic    i_clr;
		logic    i_inc;
		logic    j_load;
		logic    j_dec;
		logic    rd_en;
		ra_t     rd_sel;
		logic    wr_en;
		wa_t     wr_sel;
		wd_t     wd_sel;
		cnt_op_t cnt_op;
		logic    set_st;
		status_t st_code;
		logic    set_hit;
		logic    out_load;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic price_ok;
		logic i_eq_n;
		logic match;
		logic greater;
		logic qsum_pos;
		logic can_insert;
		logic shl_more;
		logic shr_more;
		logic idx_ok;
		logic out_free;
	} sts_t;

endpackage

/* rtl/obl_ctrl.sv */
// Controller state machine of the order book level table.
// Depends on obl_pkg; drives ctl_t commands into obl_dp.
module obl_ctrl import obl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.rd_sel = RA_I;
		ctl.wr_sel = WA_I;
		ctl.wd_sel = WD_RD;
		ctl.cnt_op = CNT_HOLD;
		ctl.st_code = ST_IGNORED;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_in = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				ctl.set_st = 1'b1;
				unique case (sts.cmd)
					CMD_APPLY: begin
						if (sts.price_ok) begin
							ctl.set_st = 1'b0;
							ctl.i_clr = 1'b1;
							state_d = S_SCAN_RD;
						end
					end
					CMD_CLEAR: begin
						ctl.cnt_op = CNT_CLR;
						ctl.st_code = ST_CLEARED;
					end
					CMD_READ: begin
						ctl.st_code = ST_READ;
						if (sts.idx_ok) begin
							ctl.rd_en = 1'b1;
							ctl.rd_sel = RA_IDX;
							ctl.set_hit = 1'b1;
						end
					end
					default: ctl.st_code = ST_IGNORED;
				endcase
			end
			// linear scan: read a level in S_SCAN_RD, evaluate it in S_SCAN_EV
			S_SCAN_RD: begin
				if (sts.i_eq_n) begin
					if (sts.can_insert) begin
						ctl.j_load = 1'b1;
						state_d = S_SHR_RD;
					end else begin
						ctl.set_st = 1'b1;
						state_d = S_DONE;
					end
				end else begin
					ctl.rd_en = 1'b1;
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (sts.match) begin
					if (sts.qsum_pos) begin
						ctl.wr_en = 1'b1;
						ctl.wd_sel = WD_SUM;
						ctl.set_st = 1'b1;
						ctl.st_code = ST_UPDATED;
						state_d = S_DONE;
					end else begin
						state_d = S_SHL_RD;
					end
				end else if (sts.greater) begin
					if (sts.can_insert) begin
						ctl.j_load = 1'b1;
						state_d = S_SHR_RD;
					end else begin
						ctl.set_st = 1'b1;
						state_d = S_DONE;
					end
				end else begin
					ctl.i_inc = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			// removal: move higher levels down one place
			S_SHL_RD: begin
				if (sts.shl_more) begin
					ctl.rd_en = 1'b1;
					ctl.rd_sel = RA_I1;
					state_d = S_SHL_WR;
				end else begin
					ctl.cnt_op = CNT_DEC;
					ctl.set_st = 1'b1;
					ctl.st_code = ST_REMOVED;
					state_d = S_DONE;
				end
			end
			S_SHL_WR: begin
				ctl.wr_en = 1'b1;
				ctl.i_inc = 1'b1;
				state_d = S_SHL_RD;
			end
			// insertion: move higher levels up one place, then write
			S_SHR_RD: begin
				if (sts.shr_more) begin
					ctl.rd_en = 1'b1;
					ctl.rd_sel = RA_J1;
					state_d = S_SHR_WR;
				end else begin
					ctl.wr_en = 1'b1;
					ctl.wd_sel = WD_NEW;
					ctl.cnt_op = CNT_INC;
					ctl.set_st = 1'b1;
					ctl.st_code = ST_INSERTED;
					state_d = S_DONE;
				end
			end
			S_SHR_WR: begin
				ctl.wr_en = 1'b1;
				ctl.wr_sel = WA_J;
				ctl.j_dec = 1'b1;
				state_d = S_SHR_RD;
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/obl_dp.sv */
// Datapath of the order book level table: level memory, counts, scan
// indices and result register. Depends on obl_pkg; driven by obl_ctrl.
module obl_dp import obl_pkg::*; #(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  command,
	input  logic        side,
	input  logic [6:0]  price,
	input  logic [31:0] delta,
	input  logic [6:0]  level_index,
	input  ctl_t        ctl,
	output sts_t        sts,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [7:0]  level_count,
	output logic [6:0]  level_price,
	output logic [6:0]  reported_price,
	output logic [30:0] level_qty,
	output logic        index_valid
);

	localparam int AW = $clog2(2 * MAX_LEVELS);
	localparam int CW = $clog2(MAX_LEVELS + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	logic [1:0]        cmd_q;
	logic              side_q;
	logic [6:0]        price_q;
	logic [31:0]       delta_q;
	logic [6:0]        idx_q;
	logic [CW-1:0]     i_q, j_q;
	logic [CW-1:0]     cnt_q [2];
	entry_t            rdata_q;
	status_t           st_q;
	logic              hit_q;
	logic              rsp_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        count_q;
	logic [6:0]        lp_q, rp_q;
	logic [30:0]       lq_q;
	logic              iv_q;
	entry_t            mem [2*MAX_LEVELS];

	logic [CW-1:0]     n;
	logic [AW-1:0]     base, rd_addr, wr_addr;
	entry_t            wr_data;
	logic signed [32:0] qsum;
	logic [30:0]       sat_qty;

	assign n    = cnt_q[side_q];
	assign base = side_q ? AW'(MAX_LEVELS) : '0;

	// address and data selection
	always_comb begin
		case (ctl.rd_sel)
			RA_I:    rd_addr = base + AW'(i_q);
			RA_I1:   rd_addr = base + AW'(i_q) + AW'(1);
			RA_J1:   rd_addr = base + AW'(j_q) - AW'(1);
			default: rd_addr = base + AW'(idx_q);
		endcase
		wr_addr = (ctl.wr_sel == WA_J) ? base + AW'(j_q) : base + AW'(i_q);
		case (ctl.wd_sel)
			WD_SUM:  wr_data = '{price: rdata_q.price, qty: sat_qty};
			WD_NEW:  wr_data = '{price: price_q, qty: delta_q[30:0]};
			default: wr_data = rdata_q;
		endcase
	end

	// sum with saturation at the top of the quantity range
	assign qsum    = $signed({2'b00, rdata_q.qty}) + $signed({delta_q[31], delta_q});
	assign sat_qty = (qsum[32:31] != 2'b00) ? QTY_MAX : qsum[30:0];

	// status towards the controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.price_ok   = (price_q <= PRICE_TOP);
		sts.i_eq_n     = (i_q == n);
		sts.match      = (rdata_q.price == price_q);
		sts.greater    = (rdata_q.price > price_q);
		sts.qsum_pos   = !qsum[32] && (qsum != '0);
		sts.can_insert = !delta_q[31] && (delta_q != '0) && (n < CW'(MAX_LEVELS));
		sts.shl_more   = (({1'b0, i_q} + (CW+1)'(1)) < {1'b0, n});
		sts.shr_more   = (j_q > i_q);
		sts.idx_ok     = (XW'(idx_q) < XW'(n));
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// level memory
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// captured transaction, indices and step status
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q   <= command;
			side_q  <= side;
			price_q <= price;
			delta_q <= delta;
			idx_q   <= level_index;
		end
		if (ctl.i_clr) begin
			i_q <= '0;
		end else if (ctl.i_inc) begin
			i_q <= i_q + CW'(1);
		end
		if (ctl.j_load) begin
			j_q <= n;
		end else if (ctl.j_dec) begin
			j_q <= j_q - CW'(1);
		end
		if (ctl.set_st) begin
			st_q <= ctl.st_code;
		end
		if (ctl.load_in) begin
			hit_q <= 1'b0;
		end else if (ctl.set_hit) begin
			hit_q <= 1'b1;
		end
	end

	// per side level counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else begin
			case (ctl.cnt_op)
				CNT_INC: cnt_q[side_q] <= n + CW'(1);
				CNT_DEC: cnt_q[side_q] <= n - CW'(1);
				CNT_CLR: cnt_q[side_q] <= '0;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q <= st_q;
			count_q  <= 8'(n);
			lp_q     <= hit_q ? rdata_q.price : '0;
			rp_q     <= !hit_q ? '0 : (side_q ? PRICE_TOP - rdata_q.price : rdata_q.price);
			lq_q     <= hit_q ? rdata_q.qty : '0;
			iv_q     <= hit_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign level_count    = count_q;
	assign level_price    = lp_q;
	assign reported_price = rp_q;
	assign level_qty      = lq_q;
	assign index_valid    = iv_q;

endmodule

/* rtl/order_book_level_table_top.sv */
// Top level of the order book level table: controller plus datapath.
// Depends on obl_pkg, obl_ctrl and obl_dp.
//
//  channel | handshake            | payload
//  request | req_valid/req_stall  | command, side, price, delta, level_index
//  result  | rsp_valid/rsp_stall  | status, level_count, level_price,
//          |                      | reported_price, level_qty, index_valid
//
// Clear, read, unknown-command and out-of-range-price transactions pass through
// S_DISPATCH and S_DONE to the result register; a new request is taken once the
// controller is back in S_IDLE. An apply scans the side's levels, reading and
// then evaluating each, through the single read port of the level memory, then
// moves the levels above, each with a read and a write, on removal or insertion.
// Reset (arst_n low) empties both sides; the memory needs no clearing.
// A new request is taken once the previous one is done, even while its
// result is still held by rsp_stall.
module order_book_level_table_top import obl_pkg::*; #(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic        side,
	input  logic [6:0]  price,
	input  logic [31:0] delta,
	input  logic [6:0]  level_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [7:0]  level_count,
	output logic [6:0]  level_price,
	output logic [6:0]  reported_price,
	output logic [30:0] level_qty,
	output logic        index_valid
);

	ctl_t ctl;
	sts_t sts;

	obl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	obl_dp #(.MAX_LEVELS(MAX_LEVELS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (command),
		.side           (side),
		.price          (price),
		.delta          (delta),
		.level_index    (level_index),
		.ctl            (ctl),
		.sts            (sts),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.level_count    (level_count),
		.level_price    (level_price),
		.reported_price (reported_price),
		.level_qty      (level_qty),
		.index_valid    (index_valid)
	);

endmodule

/* rtl/obl_checker.sv */
// Port level checks for the order book level table, bound to the top level.
// Depends on obl_pkg.
module obl_checker import obl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [2:0]  status,
	input logic [30:0] level_qty,
	input logic        index_valid
);

	// a result held by stall stays valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// a held result keeps its status
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(status))
		else $error("result changed while stalled");

	// one transaction at a time: stall rises after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second transaction taken while busy");

	// only a read result may carry level data
	a_read_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_READ |-> !index_valid && level_qty == '0)
		else $error("level data on a non-read result");

endmodule

bind order_book_level_table_top obl_checker u_obl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.level_qty   (level_qty),
	.index_valid (index_valid)
);

/* verif/order_book_level_table_top_tb.sv */
// Testbench for the order book level table: directed and random transactions
// checked against a behavioural book model held in the bench. Needs obl_pkg.
`timescale 1ns / 100ps

module order_book_level_table_top_tb;
	import obl_pkg::*;

	localparam int BOOK_DEPTH = MAX_LEVELS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 4 * BOOK_DEPTH + 16;

	typedef struct {
		logic [1:0]  cmd;
		logic        sd;
		logic [6:0]  px;
		logic [31:0] dq;
		logic [6:0]  idx;
	} order_t;

	typedef struct {
		logic [2:0]  st;
		logic [7:0]  cnt;
		logic [6:0]  lp;
		logic [6:0]  rp;
		logic [30:0] lq;
		logic        iv;
	} book_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] command = '0;
	logic side = 1'b0;
	logic [6:0] price = '0;
	logic [31:0] delta = '0;
	logic [6:0] level_index = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] level_count;
	logic [6:0] level_price;
	logic [6:0] reported_price;
	logic [30:0] level_qty;
	logic index_valid;

	order_t pending_orders[$];
	book_resp_t book_resp_due[$];

	// bench copy of both book sides
	logic [6:0]  bk_price[2][BOOK_DEPTH];
	logic [30:0] bk_qty[2][BOOK_DEPTH];
	int          bk_cnt[2];

	int  errors = 0;
	int  cycle_cnt = 0;
	int  req_gap = 0;
	int  rsp_hold = 0;
	bit  req_fired = 1'b0;
	bit  rsp_fired = 1'b0;
	bit  burst = 1'b0;

	order_book_level_table_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.command(command), .side(side), .price(price), .delta(delta),
		.level_index(level_index),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .level_count(level_count), .level_price(level_price),
		.reported_price(reported_price), .level_qty(level_qty),
		.index_valid(index_valid)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply a delta to the bench book, returning the status code
	function automatic logic [2:0] book_apply(input logic s, input logic [6:0] p,
			input logic [31:0] d);
		int n;
		int j;
		longint q;
		longint dl;
		n = bk_cnt[s];
		dl = longint'($signed(d));
		for (int i = 0; i < n; i++) begin
			if (bk_price[s][i] == p) begin
				q = longint'({33'd0, bk_qty[s][i]}) + dl;
				if (q > longint'(QTY_MAX))
					q = longint'(QTY_MAX);
				if (q <= 0) begin
					for (j = i; j + 1 < n; j++) begin
						bk_price[s][j] = bk_price[s][j+1];
						bk_qty[s][j] = bk_qty[s][j+1];
					end
					bk_cnt[s] = n - 1;
					return ST_REMOVED;
				end
				bk_qty[s][i] = q[30:0];
				return ST_UPDATED;
			end
		end
		if (dl <= 0 || n >= BOOK_DEPTH)
			return ST_IGNORED;
		// open a gap in sorted place
		j = n;
		while (j > 0 && bk_price[s][j-1] > p) begin
			bk_price[s][j] = bk_price[s][j-1];
			bk_qty[s][j] = bk_qty[s][j-1];
			j--;
		end
		bk_price[s][j] = p;
		bk_qty[s][j] = d[30:0];
		bk_cnt[s] = n + 1;
		return ST_INSERTED;
	endfunction

	// expected response for one accepted order
	function automatic book_resp_t book_predict(input order_t o);
		book_resp_t r;
		r.st = ST_IGNORED;
		r.lp = '0;
		r.rp = '0;
		r.lq = '0;
		r.iv = 1'b0;
		case (o.cmd)
			CMD_APPLY: begin
				if (o.px <= PRICE_TOP)
					r.st = book_apply(o.sd, o.px, o.dq);
			end
			CMD_CLEAR: begin
				bk_cnt[o.sd] = 0;
				r.st = ST_CLEARED;
			end
			CMD_READ: begin
				r.st = ST_READ;
				if (int'(o.idx) < bk_cnt[o.sd]) begin
					r.lp = bk_price[o.sd][o.idx];
					r.lq = bk_qty[o.sd][o.idx];
					r.rp = o.sd ? PRICE_TOP - r.lp : r.lp;
					r.iv = 1'b1;
				end
			end
			default: ;
		endcase
		r.cnt = bk_cnt[o.sd][7:0];
		return r;
	endfunction

	function automatic void queue_order(input logic [1:0] c, input logic s,
			input logic [6:0] p, input logic [31:0] d, input logic [6:0] i);
		order_t o;
		o.cmd = c;
		o.sd = s;
		o.px = p;
		o.dq = d;
		o.idx = i;
		pending_orders.push_back(o);
	endfunction

	function automatic logic [31:0] rand_delta();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return $urandom_range(1, 1000);
		if (k < 80) return -$urandom_range(1, 1500);
		if (k < 88) return $urandom();
		if (k < 93) return 32'd0;
		return 32'h7FFF_FFFF - $urandom_range(0, 3);
	endfunction

	// sample request and response handshakes
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $realtime, cycle_cnt);
			$display("FAILURE");
			$finish;
		end else if (arst_n) begin
			req_fired <= req_valid && !req_stall;
			rsp_fired <= rsp_valid && !rsp_stall;
			if (req_valid && !req_stall)
				book_resp_due.push_back(book_predict('{command, side, price, delta,
					level_index}));
			if (rsp_valid && !rsp_stall) begin
				if (book_resp_due.size() == 0) begin
					$display("%0t unexpected transaction: status %0d", $realtime, status);
					errors <= errors + 1;
				end else begin
					book_resp_t e;
					e = book_resp_due.pop_front();
					if (status !== e.st || level_count !== e.cnt || level_price !== e.lp ||
							reported_price !== e.rp || level_qty !== e.lq ||
							index_valid !== e.iv) begin
						$display("%0t mismatch exp st=%0d cnt=%0d lp=%0d rp=%0d lq=%0d iv=%0d",
							$realtime, e.st, e.cnt, e.lp, e.rp, e.lq, e.iv);
						$display("%0t          act st=%0d cnt=%0d lp=%0d rp=%0d lq=%0d iv=%0d",
							$realtime, status, level_count, level_price, reported_price,
							level_qty, index_valid);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	// request driver: hold until accepted, then idle for the drawn gap
	always @(negedge clk) begin
		order_t o;
		if (arst_n && !(req_valid && !req_fired)) begin
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_orders.size() > 0) begin
				o = pending_orders.pop_front();
				command <= o.cmd;
				side <= o.sd;
				price <= o.px;
				delta <= o.dq;
				level_index <= o.idx;
				req_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					burst <= !burst;
				req_gap <= burst ? 0 : $urandom_range(0, 14);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response stall: a fresh hold drawn per accepted result
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_fired) begin
				int h;
				h = burst ? 0 : $urandom_range(0, 14);
				rsp_hold <= h;
				rsp_stall <= (h > 0);
			end else if (rsp_hold > 0) begin
				rsp_hold <= rsp_hold - 1;
				rsp_stall <= (rsp_hold > 1);
			end
		end
	end

	initial begin
		int k;
		logic s;
		for (int b = 0; b < 2; b++) begin
			bk_cnt[b] = 0;
			for (int i = 0; i < BOOK_DEPTH; i++) begin
				bk_price[b][i] = '0;
				bk_qty[b][i] = '0;
			end
		end

		// directed: edges of each field and each corner case
		queue_order(CMD_READ, 1'b0, 7'd0, 32'd0, 7'd0);          // empty read
		queue_order(CMD_APPLY, 1'b0, 7'd101, 32'd5, 7'd0);       // price out of range
		queue_order(CMD_APPLY, 1'b0, 7'd127, 32'd5, 7'd127);
		queue_order(CMD_APPLY, 1'b0, 7'd50, 32'hFFFF_FFFF, 7'd0); // new, negative
		queue_order(CMD_APPLY, 1'b0, 7'd50, 32'd0, 7'd0);        // new, zero
		queue_order(CMD_APPLY, 1'b0, 7'd50, 32'd10, 7'd0);
		queue_order(CMD_APPLY, 1'b0, 7'd0, 32'd1, 7'd0);
		queue_order(CMD_APPLY, 1'b0, 7'd100, 32'h7FFF_FFFF, 7'd0);
		queue_order(CMD_APPLY, 1'b0, 7'd100, 32'h7FFF_FFFF, 7'd0); // saturates
		queue_order(CMD_APPLY, 1'b0, 7'd50, 32'd5, 7'd0);        // update
		queue_order(CMD_READ, 1'b0, 7'd0, 32'd0, 7'd2);
		queue_order(CMD_READ, 1'b0, 7'd0, 32'd0, 7'd3);          // out of range
		queue_order(CMD_APPLY, 1'b0, 7'd50, 32'h8000_0000, 7'd0); // removed
		queue_order(CMD_APPLY, 1'b1, 7'd30, 32'd77, 7'd0);
		queue_order(CMD_APPLY, 1'b1, 7'd100, 32'd3, 7'd0);
		queue_order(CMD_READ, 1'b1, 7'd0, 32'd0, 7'd0);          // mirrored price
		queue_order(CMD_READ, 1'b1, 7'd0, 32'd0, 7'd1);
		queue_order(CMD_READ, 1'b1, 7'd0, 32'd0, 7'd127);
		queue_order(CMD_UNUSED, 1'b1, 7'd20, 32'd9, 7'd0);
		queue_order(CMD_APPLY, 1'b1, 7'd30, -32'sd77, 7'd0);     // exactly zero
		queue_order(CMD_CLEAR, 1'b1, 7'd0, 32'd0, 7'd0);
		queue_order(CMD_READ, 1'b1, 7'd0, 32'd0, 7'd0);
		queue_order(CMD_CLEAR, 1'b0, 7'd0, 32'd0, 7'd0);

		// snapshot loads of every price, highest first so each insert shifts
		for (int b = 0; b < 2; b++) begin
			queue_order(CMD_CLEAR, b[0], 7'd0, 32'd0, 7'd0);
			for (int p = 100; p >= 0; p--)
				queue_order(CMD_APPLY, b[0], p[6:0], $urandom_range(1, 5000), 7'd0);
			queue_order(CMD_READ, b[0], 7'd0, 32'd0, 7'd100);
			queue_order(CMD_READ, b[0], 7'd0, 32'd0, 7'd101);
			queue_order(CMD_APPLY, b[0], 7'd0, -32'sd100000, 7'd0);
		end

		// random traffic, mostly well-formed book maintenance
		for (int n = 0; n < 700; n++) begin
			k = $urandom_range(0, 99);
			s = 1'($urandom_range(0, 1));
			if (k < 60)
				queue_order(CMD_APPLY, s, 7'($urandom_range(0, 100)), rand_delta(),
					7'($urandom()));
			else if (k < 85)
				queue_order(CMD_READ, s, 7'($urandom()), $urandom(),
					7'($urandom_range(0, 110)));
			else if (k < 88)
				queue_order(CMD_CLEAR, s, 7'($urandom()), $urandom(), 7'($urandom()));
			else if (k < 94)
				queue_order(CMD_APPLY, s, 7'($urandom_range(101, 127)), $urandom(),
					7'($urandom()));
			else if (k < 97)
				queue_order(CMD_UNUSED, s, 7'($urandom()), $urandom(), 7'($urandom()));
			else
				queue_order(CMD_READ, s, 7'($urandom()), $urandom(), 7'($urandom()));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_orders.size() > 0 || req_valid || book_resp_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && book_resp_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
